// ===== hw/rtl/frds_pkg.sv =====
// Package for the fractional divider rate solver.
// Holds widths, codes, the FSM state type and the beat and divider structs.
// No dependencies.
package frds_pkg;

  // Field widths
  localparam int FracBits = 14;
  localparam int IntBits  = 9;
  localparam int RateBits = 32;

  // Divider limits
  localparam int IntMin = 4;
  localparam int IntMax = (1 << IntBits) - 1;

  // Shared divider sizing: dividend is rate * 2^F plus a rounding term
  localparam int DivNBits = RateBits + FracBits + 1;
  localparam int DivDBits = (RateBits > IntBits + FracBits) ? RateBits : IntBits + FracBits;
  localparam int CntBits  = $clog2(DivNBits);
  // Integer part of the quotient, above the fraction bits
  localparam int DivHiBits = DivNBits - FracBits;

  // Operation codes
  localparam logic OpSet    = 1'b0;
  localparam logic OpRecalc = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StDivide,
    StFinish
  } state_e;

  typedef struct packed {
    logic                operation;
    logic [RateBits-1:0] src_rate;
    logic [RateBits-1:0] target_rate;
  } in_beat_t;

  typedef struct packed {
    logic [RateBits-1:0] output_rate;
    logic [IntBits-1:0]  integer_divider;
    logic [FracBits-1:0] fraction_value;
    logic                error_flag;
  } out_beat_t;

  typedef struct packed {
    logic                start;
    logic [DivNBits-1:0] dividend;
    logic [DivDBits-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DivNBits-1:0] quotient;
    logic                rem_nz;
  } div_rsp_t;

endpackage

// ===== hw/rtl/frds_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on frds_pkg (widths, div_req_t, div_rsp_t).
// Quotient and remainder flag stay stable after done until the next start.
module frds_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  frds_pkg::div_req_t req_i,
  output frds_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [frds_pkg::CntBits-1:0]  cnt_q, cnt_d;
  logic [frds_pkg::DivNBits-1:0] shreg_q, shreg_d;
  logic [frds_pkg::DivDBits-1:0] div_q, div_d;
  logic [frds_pkg::DivDBits-1:0] rem_q, rem_d;

  logic [frds_pkg::DivDBits:0]   trial;
  logic [frds_pkg::DivDBits+1:0] diff;
  logic                          qbit;

  // One restoring step: shift in next dividend bit, try subtract
  always_comb begin
    trial = {rem_q, shreg_q[frds_pkg::DivNBits-1]};
    diff  = {1'b0, trial} - {2'b00, div_q};
    qbit  = ~diff[frds_pkg::DivDBits+1];
  end

  // Sequencing of the iterations
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    shreg_d = shreg_q;
    div_d   = div_q;
    rem_d   = rem_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      shreg_d = req_i.dividend;
      div_d   = req_i.divisor;
      rem_d   = '0;
    end else if (busy_q) begin
      shreg_d = {shreg_q[frds_pkg::DivNBits-2:0], qbit};
      rem_d   = qbit ? diff[frds_pkg::DivDBits-1:0] : trial[frds_pkg::DivDBits-1:0];
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == frds_pkg::CntBits'(frds_pkg::DivNBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = shreg_q;
  assign rsp_o.rem_nz   = |rem_q;

endmodule

// ===== hw/rtl/frds_ctrl.sv =====
// Sequencer of the rate solver: handshakes, held divider settings, rounding,
// clamping and the output register. Depends on frds_pkg; drives frds_div.
module frds_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  frds_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output frds_pkg::out_beat_t out_data_o,
  output frds_pkg::div_req_t  div_req_o,
  input  frds_pkg::div_rsp_t  div_rsp_i
);

  frds_pkg::state_e              state_q, state_d;
  logic                          round_q;
  logic [frds_pkg::IntBits-1:0]  int_q;
  logic [frds_pkg::FracBits-1:0] frac_q;
  logic                          op_q;
  logic                          ceil_q;
  logic                          err_q;
  logic                          out_valid_q;
  frds_pkg::out_beat_t           out_data_q;

  logic                           accept;
  logic                           early_err;
  logic                           out_free;
  logic                           load;
  logic                           div_start;
  logic [frds_pkg::DivNBits-1:0]  q_adj;
  logic [frds_pkg::DivHiBits-1:0] q_hi;
  logic [frds_pkg::IntBits-1:0]   new_int;
  logic [frds_pkg::FracBits-1:0]  new_frac;
  frds_pkg::out_beat_t            result;

  assign accept   = in_valid_i & in_ready_o;
  assign out_free = ~out_valid_q | out_ready_i;

  // Cases that need no division
  always_comb begin
    if (in_data_i.operation == frds_pkg::OpSet) begin
      early_err = (in_data_i.target_rate == '0);
    end else begin
      early_err = (int_q < frds_pkg::IntBits'(frds_pkg::IntMin));
    end
  end

  // Divider operands: set divides parent*2^F (+T/2 for nearest) by target,
  // recalc divides parent*2^F by int*2^F+frac
  always_comb begin
    div_req_o.start    = div_start;
    div_req_o.dividend = {{(frds_pkg::DivNBits-frds_pkg::RateBits){1'b0}},
                          in_data_i.src_rate} << frds_pkg::FracBits;
    if (in_data_i.operation == frds_pkg::OpSet) begin
      if (round_q) begin
        div_req_o.dividend = div_req_o.dividend
                           + frds_pkg::DivNBits'(in_data_i.target_rate >> 1);
      end
      div_req_o.divisor = frds_pkg::DivDBits'(in_data_i.target_rate);
    end else begin
      div_req_o.divisor = frds_pkg::DivDBits'({int_q, frac_q});
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      frds_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = early_err ? frds_pkg::StFinish : frds_pkg::StDivide;
        end
      end
      frds_pkg::StDivide: begin
        if (div_rsp_i.done) begin
          state_d = frds_pkg::StFinish;
        end
      end
      frds_pkg::StFinish: begin
        if (out_free) begin
          state_d = frds_pkg::StIdle;
        end
      end
      default: state_d = frds_pkg::StIdle;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    load       = 1'b0;
    unique case (state_q)
      frds_pkg::StIdle: begin
        in_ready_o = 1'b1;
        div_start  = in_valid_i & ~early_err;
      end
      frds_pkg::StDivide: begin
      end
      frds_pkg::StFinish: begin
        load = out_free;
      end
      default: begin
      end
    endcase
  end

  // Ceiling correction and clamping of the quotient
  always_comb begin
    q_adj = div_rsp_i.quotient
          + frds_pkg::DivNBits'(ceil_q & div_rsp_i.rem_nz);
    q_hi  = q_adj[frds_pkg::DivNBits-1:frds_pkg::FracBits];
    if (q_hi < frds_pkg::DivHiBits'(frds_pkg::IntMin)) begin
      new_int  = frds_pkg::IntBits'(frds_pkg::IntMin);
      new_frac = '0;
    end else if (q_hi > frds_pkg::DivHiBits'(frds_pkg::IntMax)) begin
      new_int  = frds_pkg::IntBits'(frds_pkg::IntMax);
      new_frac = '1;
    end else begin
      new_int  = q_hi[frds_pkg::IntBits-1:0];
      new_frac = q_adj[frds_pkg::FracBits-1:0];
    end
  end

  // Result beat
  always_comb begin
    result.output_rate     = '0;
    result.integer_divider = int_q;
    result.fraction_value  = frac_q;
    result.error_flag      = err_q;
    if (!err_q) begin
      if (op_q == frds_pkg::OpSet) begin
        result.integer_divider = new_int;
        result.fraction_value  = new_frac;
      end else begin
        result.output_rate = q_adj[frds_pkg::RateBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= frds_pkg::StIdle;
      round_q     <= 1'b0;
      int_q       <= '0;
      frac_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        round_q <= cfg_data_i;
      end
      if (load) begin
        int_q  <= result.integer_divider;
        frac_q <= result.fraction_value;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-item context and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_data_i.operation;
      ceil_q <= (in_data_i.operation == frds_pkg::OpRecalc) | ~round_q;
      err_q  <= early_err;
    end
    if (load) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/fractional_divider_rate_solver_top.sv =====
// Top level of the fractional divider rate solver.
// Depends on frds_pkg, frds_ctrl and frds_div.
//
//   port group  | dir | handshake          | payload
//   in_*        | in  | in_valid/in_ready  | in_beat_t (operation, parent, target)
//   out_*       | out | out_valid/out_ready| out_beat_t (rate, int, frac, error)
//   cfg_*       | in  | cfg_we, no wait    | round_closest bit
//
// A set or recalc beat is accepted, then runs one iteration of the shared
// restoring divider per dividend bit (one quotient bit each), one step to
// report done and one to round, clamp and load the output register. Error
// beats (zero target, divider below four) skip the divider.
// The block takes no new beat until the current one has been written to the
// output register; a stalled output holds the block in its final step.
// Reset clears the held divider to zero and round_closest to 0.
module fractional_divider_rate_solver_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  frds_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output frds_pkg::out_beat_t out_data_o
);

  frds_pkg::div_req_t div_req;
  frds_pkg::div_rsp_t div_rsp;

  frds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp)
  );

  frds_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

endmodule

// ===== hw/rtl/frds_checker.sv =====
// Port-level checker for the fractional divider rate solver, bound to the top.
// Depends on frds_pkg and fractional_divider_rate_solver_top.
module frds_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input frds_pkg::out_beat_t out_data_o
);

  // A stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // One beat at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while previous beat in flight");

  // Error beats carry no rate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error_flag |-> out_data_o.output_rate == '0)
    else $error("error beat with nonzero rate");

  // Good beats always show a divider of at least four
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.error_flag |->
      out_data_o.integer_divider >= frds_pkg::IntBits'(frds_pkg::IntMin))
    else $error("good beat with divider below minimum");

endmodule

bind fractional_divider_rate_solver_top frds_checker u_frds_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

// ===== dv/tb_fractional_divider_rate_solver_top.sv =====
// Testbench for fractional_divider_rate_solver_top: random and directed set/recalc beats,
// predicted in-line and checked field by field. Depends on frds_pkg and the RTL top.
`timescale 1ns / 100ps

module tb_fractional_divider_rate_solver_top;

  localparam int unsigned SettleCycles = 60;   // a bit more than one full divide
  localparam int unsigned RandomPhases = 4;
  localparam int unsigned PhaseBeats   = 400;
  localparam int unsigned HoldBeat     = 300;  // output beat that starts the long hold
  localparam int unsigned HoldCycles   = 400;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_data_i = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  frds_pkg::in_beat_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  frds_pkg::out_beat_t out_data_o;

  // Predictor copy of the held divider and the rounding mode
  logic [frds_pkg::IntBits-1:0]  held_int = '0;
  logic [frds_pkg::FracBits-1:0] held_frac = '0;
  logic                          round_nearest = 1'b0;

  frds_pkg::in_beat_t  pending_requests[$];
  frds_pkg::out_beat_t expected_settings[$];
  int unsigned send_wait, recv_wait, sent_beats, got_beats;
  int unsigned mismatches = 0;

  fractional_divider_rate_solver_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Expected result of one request; updates the held divider on a good set
  function automatic frds_pkg::out_beat_t solve_divider(frds_pkg::in_beat_t req);
    frds_pkg::out_beat_t res;
    longint unsigned     par, tgt, quo, scaled, frac, den, num;
    res = '0;
    par = req.src_rate;
    tgt = req.target_rate;
    if (req.operation == frds_pkg::OpSet) begin
      if (tgt == 0) begin
        res.error_flag = 1'b1;
      end else begin
        quo    = par / tgt;
        scaled = (par % tgt) << frds_pkg::FracBits;
        if (round_nearest) frac = (scaled + tgt / 2) / tgt;
        else frac = scaled / tgt + ((scaled % tgt) != 0);
        // full fraction carries into the integer part
        if (frac == (64'd1 << frds_pkg::FracBits)) begin
          frac = 0;
          quo  = quo + 1;
        end
        if (quo < frds_pkg::IntMin) begin
          quo  = frds_pkg::IntMin;
          frac = 0;
        end else if (quo > frds_pkg::IntMax) begin
          quo  = frds_pkg::IntMax;
          frac = (64'd1 << frds_pkg::FracBits) - 1;
        end
        held_int  = quo[frds_pkg::IntBits-1:0];
        held_frac = frac[frds_pkg::FracBits-1:0];
      end
    end else if (held_int < frds_pkg::IntMin) begin
      res.error_flag = 1'b1;
    end else begin
      den = (64'(held_int) << frds_pkg::FracBits) + 64'(held_frac);
      num = par << frds_pkg::FracBits;
      res.output_rate = 32'(num / den + ((num % den) != 0));
    end
    res.integer_divider = held_int;
    res.fraction_value  = held_frac;
    return res;
  endfunction

  // Idle cycles before the n-th beat; every 200 beats starts with a burst of 40
  function automatic int unsigned draw_gap(int unsigned n);
    return ((n % 200) < 40) ? 0 : $urandom_range(0, 19);
  endfunction

  // Random request, mostly sets whose quotient lands inside the divider range
  function automatic frds_pkg::in_beat_t random_request();
    frds_pkg::in_beat_t req;
    int unsigned        pick, quo;
    longint unsigned    tgt, lim, base;
    req.operation   = ($urandom_range(0, 2) == 0) ? frds_pkg::OpRecalc : frds_pkg::OpSet;
    req.src_rate    = $urandom();
    req.target_rate = $urandom();
    pick = $urandom_range(0, 99);
    if (req.operation == frds_pkg::OpRecalc) begin
      if (pick < 25) req.src_rate = $urandom() & 32'hFFFF;
    end else if (pick < 55) begin
      quo = $urandom_range(frds_pkg::IntMin, frds_pkg::IntMax);
      lim = 64'hFFFF_FFFF / (quo + 1);
      tgt = 1 + (($urandom() >> $urandom_range(0, 31)) % lim);
      case ($urandom_range(0, 3))
        0:       base = 0;
        1:       base = tgt - 1;
        2:       base = tgt / 2;
        default: base = $urandom() % tgt;
      endcase
      req.target_rate = tgt[31:0];
      req.src_rate    = 32'(quo * tgt + base);
    end else if (pick < 65) begin
      // quotient below four
      tgt = 1 + ($urandom() >> $urandom_range(0, 31));
      lim = 4 * tgt;
      req.target_rate = tgt[31:0];
      req.src_rate    = (lim > 64'hFFFF_FFFF) ? $urandom() : 32'($urandom() % lim);
    end else if (pick < 75) begin
      // quotient above the integer maximum
      tgt = $urandom_range(1, 32'h7F_FFFF) >> $urandom_range(0, 22);
      if (tgt == 0) tgt = 1;
      base = 512 * tgt;
      req.target_rate = tgt[31:0];
      req.src_rate    = 32'(base + ($urandom() % (64'h1_0000_0000 - base)));
    end else if (pick < 80) begin
      req.target_rate = '0;
    end
    return req;
  endfunction

  task automatic queue_request(logic op, logic [31:0] src, logic [31:0] target);
    frds_pkg::in_beat_t req;
    req.operation   = op;
    req.src_rate    = src;
    req.target_rate = target;
    pending_requests.push_back(req);
  endtask

  // Wait until every request has been answered, then let the block go quiet
  task automatic settle();
    while (pending_requests.size() != 0 || in_valid_i || expected_settings.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_round_mode(logic nearest);
    @(posedge clk_i);
    cfg_we_i      <= 1'b1;
    cfg_data_i    <= nearest;
    round_nearest = nearest;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Input driver: predicts each accepted beat, then draws the gap to the next
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    int unsigned gap;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_wait  <= 0;
      sent_beats <= 0;
    end else if (in_valid_i && in_ready_o) begin
      expected_settings.push_back(solve_divider(in_data_i));
      sent_beats <= sent_beats + 1;
      gap = draw_gap(sent_beats + 1);
      if (gap == 0 && pending_requests.size() != 0) begin
        in_data_i <= pending_requests.pop_front();
      end else begin
        in_valid_i <= 1'b0;
        send_wait  <= gap;
      end
    end else if (!in_valid_i) begin
      if (send_wait != 0) begin
        send_wait <= send_wait - 1;
      end else if (pending_requests.size() != 0) begin
        in_data_i  <= pending_requests.pop_front();
        in_valid_i <= 1'b1;
      end
    end
  end

  // Output monitor and receiver stalls, with one long hold to back up the input
  always @(posedge clk_i or negedge rst_ni) begin : receive_proc
    frds_pkg::out_beat_t want;
    int unsigned         stall;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_wait   <= 0;
      got_beats   <= 0;
    end else if (out_valid_o && out_ready_i) begin
      if (expected_settings.size() == 0) begin
        $error("output beat with no request outstanding");
        mismatches++;
      end else begin
        want = expected_settings.pop_front();
        if (out_data_o.output_rate !== want.output_rate) begin
          $error("output_rate: expected %0d, got %0d", want.output_rate,
                 out_data_o.output_rate);
          mismatches++;
        end
        if (out_data_o.integer_divider !== want.integer_divider) begin
          $error("integer_divider: expected %0d, got %0d", want.integer_divider,
                 out_data_o.integer_divider);
          mismatches++;
        end
        if (out_data_o.fraction_value !== want.fraction_value) begin
          $error("fraction_value: expected %0d, got %0d", want.fraction_value,
                 out_data_o.fraction_value);
          mismatches++;
        end
        if (out_data_o.error_flag !== want.error_flag) begin
          $error("error_flag: expected %0d, got %0d", want.error_flag,
                 out_data_o.error_flag);
          mismatches++;
        end
      end
      got_beats <= got_beats + 1;
      stall = (got_beats + 1 == HoldBeat) ? HoldCycles : draw_gap(got_beats + 1);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        recv_wait   <= stall;
      end
    end else if (!out_ready_i) begin
      if (recv_wait != 0) recv_wait <= recv_wait - 1;
      else out_ready_i <= 1'b1;
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Round-up mode: reset state, errors, clamps and the fraction carry
    write_round_mode(1'b0);
    queue_request(frds_pkg::OpRecalc, 32'd1000, 32'd0);            // divider still zero
    queue_request(frds_pkg::OpSet, 32'd5000, 32'd0);               // zero target
    queue_request(frds_pkg::OpRecalc, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(frds_pkg::OpSet, 32'd0, 32'd1);                  // low clamp
    queue_request(frds_pkg::OpRecalc, 32'hFFFF_FFFF, 32'd0);
    queue_request(frds_pkg::OpSet, 32'hFFFF_FFFF, 32'd1);          // high clamp
    queue_request(frds_pkg::OpRecalc, 32'hFFFF_FFFF, 32'd7);
    queue_request(frds_pkg::OpSet, 32'd98309, 32'd16385);          // fraction carries to 6.0
    queue_request(frds_pkg::OpSet, 32'd100001, 32'd1000);
    queue_request(frds_pkg::OpSet, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // quotient one
    queue_request(frds_pkg::OpSet, 32'd1535, 32'd3);               // 511 with a fraction
    queue_request(frds_pkg::OpSet, 32'd3584, 32'd7);               // quotient 512
    queue_request(frds_pkg::OpSet, 32'd0, 32'd0);
    queue_request(frds_pkg::OpRecalc, 32'd0, 32'hFFFF_FFFF);
    queue_request(frds_pkg::OpSet, 32'hFFFF_FFFF, 32'h00FF_FFFF);
    queue_request(frds_pkg::OpRecalc, 32'd1, 32'd0);
    queue_request(frds_pkg::OpSet, 32'hFFFF_FFFF, 32'h8000_0000);
    settle();

    // Round-to-nearest mode: carry, exact half and rounding down
    write_round_mode(1'b1);
    queue_request(frds_pkg::OpSet, 32'd599999, 32'd100000);        // rounds up to 6.0
    queue_request(frds_pkg::OpSet, 32'd9, 32'd2);                  // exact half
    queue_request(frds_pkg::OpSet, 32'd31, 32'd3);                 // rounds down
    queue_request(frds_pkg::OpRecalc, 32'h1234_5678, 32'd0);
    queue_request(frds_pkg::OpSet, 32'hFFFF_FFFF, 32'h007F_FFFF);
    queue_request(frds_pkg::OpSet, 32'hFFFF_FFFF, 32'd0);
    queue_request(frds_pkg::OpRecalc, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Random phases, alternating the rounding mode
    for (int ph = 0; ph < RandomPhases; ph++) begin
      settle();
      write_round_mode(ph % 2 == 1);
      for (int n = 0; n < PhaseBeats; n++) pending_requests.push_back(random_request());
    end

    settle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/frds_pkg.sv
hw/rtl/frds_div.sv
hw/rtl/frds_ctrl.sv
hw/rtl/fractional_divider_rate_solver_top.sv
hw/rtl/frds_checker.sv
dv/tb_fractional_divider_rate_solver_top.sv
